// File: hw/rtl/lpc_pkg.sv
package lpc_pkg;

  localparam int IDX_W = 12;
  localparam int VAL_W = 13;
  localparam int LBL_W = 11;
  localparam int CNT_W = 16;
  localparam int VC_W  = 11;

  localparam logic [1:0] MODE_LOAD_ROW = 2'd0;
  localparam logic [1:0] MODE_LOAD_NBR = 2'd1;
  localparam logic [1:0] MODE_START    = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_ITER_LIMIT   = 1'b1;

  localparam logic KIND_SWEEPS = 1'b0;
  localparam logic KIND_LABEL  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW0,
    ST_ROW1,
    ST_ROW2,
    ST_EDGE,
    ST_NBR,
    ST_LBL,
    ST_WB
  } state_t;

  typedef struct packed {
    logic             busy;
    logic             finish;
    logic [CNT_W-1:0] sweeps;
  } lpc_status_t;

endpackage

// File: hw/rtl/lpc_ram.sv
module lpc_ram
  import lpc_pkg::*;
#(
  parameter int WIDTH = 13,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lpc_sweep.sv
module lpc_sweep
  import lpc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int NW           = 11,
  parameter int GAW          = 13,
  parameter int VAW          = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic [NW-1:0]      n_i,
  input  logic [CNT_W-1:0]   limit_i,
  output logic [GAW-1:0]     graph_raddr,
  input  logic [VAL_W-1:0]   graph_rdata,
  output logic [VAW-1:0]     lbl_raddr,
  input  logic [LBL_W-1:0]   lbl_rdata,
  output logic               lbl_we,
  output logic [VAW-1:0]     lbl_waddr,
  output logic [LBL_W-1:0]   lbl_wdata,
  output lpc_status_t        status
);

  localparam int NB_BASE = MAX_VERTICES + 1;
  localparam int EW      = $clog2(MAX_EDGES + 1);
  localparam int OW      = (EW > VAL_W) ? EW : VAL_W;
  localparam int CMPW    = (NW > VAL_W) ? NW : VAL_W;

  state_t           state_r, state_nxt;
  logic [NW-1:0]    v_r, v_nxt;
  logic [OW-1:0]    e_r, e_nxt;
  logic [OW-1:0]    stop_r, stop_nxt;
  logic [LBL_W-1:0] best_r, best_nxt;
  logic [LBL_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] iters_r, iters_nxt;
  logic             any_r, any_nxt;

  logic [CNT_W-1:0] iters_new;
  logic             any_upd;
  logic             last_v;

  assign iters_new = (iters_r == {CNT_W{1'b1}}) ? iters_r : iters_r + CNT_W'(1);
  assign any_upd   = any_r | (best_r < cur_r);
  assign last_v    = ((v_r + NW'(1)) == n_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iters_r <= '0;
      any_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iters_r <= iters_nxt;
      any_r   <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    e_r    <= e_nxt;
    stop_r <= stop_nxt;
    best_r <= best_nxt;
    cur_r  <= cur_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    e_nxt         = e_r;
    stop_nxt      = stop_r;
    best_nxt      = best_r;
    cur_nxt       = cur_r;
    iters_nxt     = iters_r;
    any_nxt       = any_r;
    graph_raddr   = GAW'(v_r);
    lbl_raddr     = VAW'(v_r);
    lbl_we        = 1'b0;
    lbl_waddr     = VAW'(v_r);
    lbl_wdata     = best_r;
    status.busy   = (state_r != ST_IDLE);
    status.finish = 1'b0;
    status.sweeps = iters_new;

    unique case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          iters_nxt = '0;
          any_nxt   = 1'b0;
          v_nxt     = '0;
          if (n_i == '0) begin
            status.finish = 1'b1;
            status.sweeps = '0;
          end else begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        lbl_we    = 1'b1;
        lbl_wdata = LBL_W'(v_r + NW'(1));
        if (last_v) begin
          v_nxt     = '0;
          state_nxt = ST_ROW0;
        end else begin
          v_nxt = v_r + NW'(1);
        end
      end
      ST_ROW0: begin
        graph_raddr = GAW'(v_r);
        state_nxt   = ST_ROW1;
      end
      ST_ROW1: begin
        // Start offset arrives; fetch the end offset and this vertex's label.
        e_nxt       = OW'(graph_rdata);
        graph_raddr = GAW'(v_r + NW'(1));
        lbl_raddr   = VAW'(v_r);
        state_nxt   = ST_ROW2;
      end
      ST_ROW2: begin
        stop_nxt  = (OW'(graph_rdata) > OW'(MAX_EDGES)) ? OW'(MAX_EDGES) : OW'(graph_rdata);
        cur_nxt   = lbl_rdata;
        best_nxt  = lbl_rdata;
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        if (e_r < stop_r) begin
          graph_raddr = GAW'(NB_BASE + int'(e_r));
          state_nxt   = ST_NBR;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_NBR: begin
        if (CMPW'(graph_rdata) < CMPW'(n_i)) begin
          lbl_raddr = VAW'(graph_rdata);
          state_nxt = ST_LBL;
        end else begin
          e_nxt     = e_r + OW'(1);
          state_nxt = ST_EDGE;
        end
      end
      ST_LBL: begin
        if (lbl_rdata < best_r) begin
          best_nxt = lbl_rdata;
        end
        e_nxt     = e_r + OW'(1);
        state_nxt = ST_EDGE;
      end
      ST_WB: begin
        // The label write lands before any later read, so in-place updates
        // are seen by the vertices that follow in the same sweep.
        lbl_we    = (best_r < cur_r);
        lbl_waddr = VAW'(v_r);
        lbl_wdata = best_r;
        if (last_v) begin
          if (!any_upd || ((limit_i != '0) && (iters_new >= limit_i))) begin
            status.finish = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            iters_nxt = iters_new;
            any_nxt   = 1'b0;
            v_nxt     = '0;
            state_nxt = ST_ROW0;
          end
        end else begin
          any_nxt   = any_upd;
          v_nxt     = v_r + NW'(1);
          state_nxt = ST_ROW0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/label_propagation_components.sv
// Connected components by label propagation over a graph in compressed sparse
// row form. Items arrive on start/busy with in_mode, in_index and in_value; an
// item transfers at a clock edge with start high and busy low.
// Row offset and neighbor loads write the graph memory and give no result;
// they can follow each other every cycle while busy is low.
// A label read gives its result on out_valid in the cycle after the transfer,
// and reads can also follow each other every cycle while busy is low.
// A start raises busy, writes the initial labels (one vertex a cycle), then
// sweeps. Per vertex a sweep reads the row offsets and the vertex label,
// then each neighbor and, if below the vertex count, its label, one read
// at a time through the single read port of each memory, and writes back a
// smaller label if found. The sweep count appears in the cycle after the
// final sweep ends; a start with no vertices answers in the next cycle.
// Results are one-cycle strobes on out_valid; the receiver cannot stall them.
// Configuration writes (cfg_valid, cfg_ready always high) must be made while
// the block is idle, which it does not enforce. Reset clears control state
// and both registers; memory contents are kept and need no clearing pass.
module label_propagation_components
  import lpc_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_mode,
  input  logic [IDX_W-1:0] in_index,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic             out_kind,
  output logic [CNT_W-1:0] out_sweeps,
  output logic [LBL_W-1:0] out_label,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int GD      = MAX_VERTICES + 1 + MAX_EDGES;
  localparam int GAW     = $clog2(GD);
  localparam int VAW     = $clog2(MAX_VERTICES);
  localparam int VCW     = $clog2(MAX_VERTICES + 1);
  localparam int NW      = (VCW > VC_W) ? VCW : VC_W;
  localparam int NB_BASE = MAX_VERTICES + 1;

  logic [VC_W-1:0]  vcount_r;
  logic [CNT_W-1:0] limit_r;
  logic [NW-1:0]    n_act;

  logic             accept;
  logic             graph_we;
  logic [GAW-1:0]   graph_waddr;
  logic             host_rd;

  logic [GAW-1:0]   graph_raddr;
  logic [VAL_W-1:0] graph_rdata;
  logic [VAW-1:0]   eng_lbl_raddr;
  logic [VAW-1:0]   lbl_raddr;
  logic [LBL_W-1:0] lbl_rdata;
  logic             lbl_we;
  logic [VAW-1:0]   lbl_waddr;
  logic [LBL_W-1:0] lbl_wdata;
  lpc_status_t      eng_status;

  logic             out_valid_r;
  logic             out_kind_r;
  logic [CNT_W-1:0] out_sweeps_r;
  logic             out_inrange_r;

  assign cfg_ready = 1'b1;
  assign busy      = eng_status.busy;
  assign accept    = start && !busy;
  assign n_act     = (int'(vcount_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      limit_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: vcount_r <= cfg_data[VC_W-1:0];
        REG_ITER_LIMIT:   limit_r  <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    graph_we    = 1'b0;
    graph_waddr = GAW'(in_index);
    host_rd     = 1'b0;
    unique case (in_mode)
      MODE_LOAD_ROW: begin
        graph_we    = accept && (int'(in_index) <= MAX_VERTICES);
        graph_waddr = GAW'(in_index);
      end
      MODE_LOAD_NBR: begin
        graph_we    = accept && (int'(in_index) < MAX_EDGES);
        graph_waddr = GAW'(NB_BASE + int'(in_index));
      end
      MODE_READ: begin
        host_rd = accept;
      end
      default: ;
    endcase
  end

  assign lbl_raddr = busy ? eng_lbl_raddr : VAW'(in_index);

  lpc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (GD)
  ) u_graph_ram (
    .clk   (clk),
    .wen   (graph_we),
    .waddr (graph_waddr),
    .wdata (in_value),
    .raddr (graph_raddr),
    .rdata (graph_rdata)
  );

  lpc_ram #(
    .WIDTH (LBL_W),
    .DEPTH (MAX_VERTICES)
  ) u_label_ram (
    .clk   (clk),
    .wen   (lbl_we),
    .waddr (lbl_waddr),
    .wdata (lbl_wdata),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  lpc_sweep #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .NW           (NW),
    .GAW          (GAW),
    .VAW          (VAW)
  ) u_sweep (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (accept && (in_mode == MODE_START)),
    .n_i         (n_act),
    .limit_i     (limit_r),
    .graph_raddr (graph_raddr),
    .graph_rdata (graph_rdata),
    .lbl_raddr   (eng_lbl_raddr),
    .lbl_rdata   (lbl_rdata),
    .lbl_we      (lbl_we),
    .lbl_waddr   (lbl_waddr),
    .lbl_wdata   (lbl_wdata),
    .status      (eng_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= host_rd || eng_status.finish;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r    <= host_rd ? KIND_LABEL : KIND_SWEEPS;
    out_sweeps_r  <= eng_status.finish ? eng_status.sweeps : '0;
    out_inrange_r <= (int'(in_index) < int'(n_act));
  end

  // The label memory's read register holds the data for the read that
  // transferred in the previous cycle.
  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_sweeps = out_sweeps_r;
  assign out_label  = ((out_kind_r == KIND_LABEL) && out_inrange_r) ? lbl_rdata : '0;

endmodule

// File: hw/rtl/lpc_checker.sv
module lpc_checker
  import lpc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [1:0]       in_mode,
  input logic             out_valid,
  input logic             out_kind,
  input logic [CNT_W-1:0] out_sweeps,
  input logic [LBL_W-1:0] out_label
);

  // A read transfer answers in the next cycle with a label result.
  a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_READ)) |=> (out_valid && (out_kind == KIND_LABEL)))
    else $error("label read did not answer in the next cycle");

  // A start either runs (busy) or, with no vertices, answers at once.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_START)) |=> (busy || (out_valid && !out_kind)))
    else $error("start neither ran nor answered");

  // The end of a run delivers the sweep count.
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && (out_kind == KIND_SWEEPS)))
    else $error("run ended without a sweep count result");

  // No result shows while a run is in progress.
  a_quiet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> !out_valid)
    else $error("result strobe during a run");

  a_unused_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind ? (out_sweeps == '0) : (out_label == '0)))
    else $error("unused result field is not zero");

endmodule

bind label_propagation_components lpc_checker u_lpc_checker (.*);
